@@ hdl/multichannel_type_length_deframer_top_macros.svh @@
// Assertion macros for the deframer top.
// Each macro takes a label, the clock, the active-low reset, the condition,
// the consequence and a message string.
`ifndef MULTICHANNEL_TYPE_LENGTH_DEFRAMER_TOP_MACROS_SVH
`define MULTICHANNEL_TYPE_LENGTH_DEFRAMER_TOP_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define TLVD_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define TLVD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tlvd_pkg.sv @@
package tlvd_pkg;

    localparam int CH_W = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 32;
    localparam int CNT_W = 3;

    // Type byte plus four length bytes.
    localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(5);
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(1024 * 10);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_OPEN = 1'b1;

    localparam logic PHASE_WAIT_TYPE = 1'b0;
    localparam logic PHASE_IN_MSG = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [BYTE_W-1:0] message_type;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              last;
        logic              length_error;
    } t_out_item;

    // Context of one channel.
    typedef struct packed {
        logic              phase;
        logic [CNT_W-1:0]  byte_count;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] current_type;
    } t_ctx;

endpackage

@@ hdl/tlvd_if.sv @@
interface tlvd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [tlvd_pkg::CH_W-1:0]     channel;
    logic [tlvd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, kind, channel, data_byte, input ready);
    modport sink (input valid, kind, channel, data_byte, output ready);
endinterface

interface tlvd_out_if;
    logic                          valid;
    logic                          ready;
    logic [tlvd_pkg::CH_W-1:0]     out_channel;
    logic [tlvd_pkg::BYTE_W-1:0]   message_type;
    logic [tlvd_pkg::BYTE_W-1:0]   payload_byte;
    logic                          has_byte;
    logic                          last;
    logic                          length_error;

    modport source (output valid, out_channel, message_type, payload_byte, has_byte, last,
                    length_error, input ready);
    modport sink (input valid, out_channel, message_type, payload_byte, has_byte, last,
                  length_error, output ready);
endinterface

@@ hdl/tlvd_ctx_store.sv @@
module tlvd_ctx_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_rd_idx,
    output tlvd_pkg::t_ctx     o_rd_ctx,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_idx,
    input  tlvd_pkg::t_ctx     i_wr_ctx
);

    tlvd_pkg::t_ctx r_ctx [DEPTH];

    // Only the phase needs clearing: a channel waiting for a type byte
    // rebuilds the rest of its context from scratch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_ctx[i].phase <= tlvd_pkg::PHASE_WAIT_TYPE;
            end
        end else if (i_wr_en) begin
            r_ctx[i_wr_idx] <= i_wr_ctx;
        end
    end

    assign o_rd_ctx = r_ctx[i_rd_idx];

endmodule

@@ hdl/multichannel_type_length_deframer_top.sv @@
// Multichannel type-length deframer.
// Requests enter on i_in: each is either a data byte for one channel or an
// open event that clears that channel's context. A message on a channel is
// one type byte, a four-byte little-endian length and then the payload.
// Results leave on o_out: one per payload byte, tagged with the channel and
// type and marked last on the final byte. An empty message gives a single
// result without a byte; a length above max_payload gives a single error
// result, and the channel then waits for a new type byte.
// Each request is registered in the input stage and its result in the
// result register that drives o_out. One request is taken every cycle
// unless the input stage holds a stalled result; the per-channel context
// is read, updated and written back within the one stage, so requests on
// the same channel may follow each other directly. Reset clears every
// channel to waiting for a type byte and loads max_payload with 10240; no
// clearing pass is needed. When the receiver stalls, the result register
// holds its request and the input stage holds one more; i_in.ready falls
// only when that stage holds a request that would give a result. Requests
// that give no result still pass. The user must write max_payload through
// i_cfg_we and i_cfg_data only while idle; the block does not enforce it.
`include "multichannel_type_length_deframer_top_macros.svh"

module multichannel_type_length_deframer_top #(
    parameter int CHANNELS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tlvd_in_if.sink                       i_in,
    tlvd_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [tlvd_pkg::LEN_W-1:0]    i_cfg_data
);

    // The channel field is four bits wide, so no more than sixteen contexts
    // can ever be addressed.
    localparam int MAX_CH = 1 << tlvd_pkg::CH_W;
    localparam int DEPTH = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [tlvd_pkg::CH_W:0] CH_LIMIT = (tlvd_pkg::CH_W + 1)'(DEPTH);

    logic                         r_s1_valid;
    tlvd_pkg::t_in_item           r_s1;
    logic                         r_out_valid;
    tlvd_pkg::t_out_item          r_out;
    logic [tlvd_pkg::LEN_W-1:0]   r_max_payload;

    tlvd_pkg::t_ctx               rd_ctx;
    tlvd_pkg::t_ctx               n_ctx;
    tlvd_pkg::t_out_item          n_out;
    logic                         ctx_wr;
    logic                         s1_has_res;
    logic                         s1_go;
    logic                         in_range;
    logic                         in_accept;
    logic [IDX_W-1:0]             s1_idx;

    assign s1_idx = r_s1.channel[IDX_W-1:0];

    tlvd_ctx_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctx_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (s1_idx),
        .o_rd_ctx (rd_ctx),
        .i_wr_en  (ctx_wr & s1_go),
        .i_wr_idx (s1_idx),
        .i_wr_ctx (n_ctx)
    );

    // The stage moves on when it gives no result or the result register
    // will be free at this edge.
    assign s1_go = r_s1_valid && (!s1_has_res || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_accept = i_in.valid && i_in.ready;

    assign in_range = {1'b0, r_s1.channel} < CH_LIMIT;

    // Per-request work on the channel context.
    always_comb begin
        n_ctx = rd_ctx;
        n_out = '0;
        ctx_wr = 1'b0;
        s1_has_res = 1'b0;
        n_out.out_channel = r_s1.channel;
        n_out.message_type = rd_ctx.current_type;
        if (in_range) begin
            if (r_s1.kind == tlvd_pkg::KIND_OPEN) begin
                n_ctx = '0;
                ctx_wr = 1'b1;
            end else if (rd_ctx.phase == tlvd_pkg::PHASE_WAIT_TYPE) begin
                n_ctx.phase = tlvd_pkg::PHASE_IN_MSG;
                n_ctx.byte_count = tlvd_pkg::CNT_W'(1);
                n_ctx.payload_length = '0;
                n_ctx.current_type = r_s1.data_byte;
                ctx_wr = 1'b1;
            end else if (rd_ctx.byte_count < tlvd_pkg::HEADER_BYTES) begin
                // Length bytes arrive least significant first.
                case (rd_ctx.byte_count)
                    tlvd_pkg::CNT_W'(1): n_ctx.payload_length[7:0] =
                        rd_ctx.payload_length[7:0] | r_s1.data_byte;
                    tlvd_pkg::CNT_W'(2): n_ctx.payload_length[15:8] =
                        rd_ctx.payload_length[15:8] | r_s1.data_byte;
                    tlvd_pkg::CNT_W'(3): n_ctx.payload_length[23:16] =
                        rd_ctx.payload_length[23:16] | r_s1.data_byte;
                    tlvd_pkg::CNT_W'(4): n_ctx.payload_length[31:24] =
                        rd_ctx.payload_length[31:24] | r_s1.data_byte;
                    default: n_ctx.payload_length = rd_ctx.payload_length;
                endcase
                n_ctx.byte_count = rd_ctx.byte_count + tlvd_pkg::CNT_W'(1);
                ctx_wr = 1'b1;
                if (n_ctx.byte_count == tlvd_pkg::HEADER_BYTES) begin
                    if (n_ctx.payload_length == '0) begin
                        n_ctx.phase = tlvd_pkg::PHASE_WAIT_TYPE;
                        s1_has_res = 1'b1;
                        n_out.last = 1'b1;
                    end else if (n_ctx.payload_length > r_max_payload) begin
                        n_ctx.phase = tlvd_pkg::PHASE_WAIT_TYPE;
                        s1_has_res = 1'b1;
                        n_out.last = 1'b1;
                        n_out.length_error = 1'b1;
                    end
                end
            end else begin
                // During the payload the length counts the bytes still due.
                n_ctx.payload_length = rd_ctx.payload_length - tlvd_pkg::LEN_W'(1);
                ctx_wr = 1'b1;
                s1_has_res = 1'b1;
                n_out.payload_byte = r_s1.data_byte;
                n_out.has_byte = 1'b1;
                if (n_ctx.payload_length == '0) begin
                    n_out.last = 1'b1;
                    n_ctx.phase = tlvd_pkg::PHASE_WAIT_TYPE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.kind <= i_in.kind;
            r_s1.channel <= i_in.channel;
            r_s1.data_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_has_res) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= tlvd_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_channel = r_out.out_channel;
    assign o_out.message_type = r_out.message_type;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.has_byte = r_out.has_byte;
    assign o_out.last = r_out.last;
    assign o_out.length_error = r_out.length_error;

    // A waiting result must never be overwritten by the stage behind it.
    `TLVD_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n,
        r_s1_valid && s1_has_res && r_out_valid && !o_out.ready, !s1_go && !i_in.ready,
        "result register overrun")
    // A stalled request stays in the input stage.
    `TLVD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_go, r_s1_valid,
        "input stage lost a stalled request")
    // An error result closes the message and carries no byte.
    `TLVD_ASSERT_NOW(a_err_shape, i_clk, i_rst_n, r_out_valid && r_out.length_error,
        r_out.last && !r_out.has_byte && (r_out.payload_byte == '0),
        "malformed length error result")
    // Results without a byte only ever close a message.
    `TLVD_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, r_out_valid && !r_out.has_byte,
        r_out.last && (r_out.payload_byte == '0), "byteless result not marked last")

endmodule

@@ verif/tlvd_frame_checker.sv @@
module tlvd_frame_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tlvd_in_if                         i_req,
    tlvd_out_if                        i_res,
    input  logic                       i_cfg_we,
    input  logic [tlvd_pkg::LEN_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlvd_pkg::*;

    localparam int NUM_CH = 1 << CH_W;

    // Shadow of the per-channel receive context.
    logic              phase_q     [NUM_CH];
    logic [CNT_W-1:0]  hdr_cnt_q   [NUM_CH];
    logic [LEN_W-1:0]  remaining_q [NUM_CH];
    logic [BYTE_W-1:0] msg_type_q  [NUM_CH];
    logic [LEN_W-1:0]  max_payload_q;

    t_out_item expected_results[$];
    int        mismatches = 0;

    // Advances one channel by one request and gives the result it causes, if any.
    task automatic deframe_step(input t_in_item req, output bit produced,
                                output t_out_item res);
        int ch;
        ch = int'(req.channel);
        produced = 1'b0;
        res = '0;
        res.out_channel = req.channel;
        if (req.kind == KIND_OPEN) begin
            phase_q[ch] = PHASE_WAIT_TYPE;
            hdr_cnt_q[ch] = '0;
            remaining_q[ch] = '0;
            msg_type_q[ch] = '0;
        end else if (phase_q[ch] == PHASE_WAIT_TYPE) begin
            msg_type_q[ch] = req.data_byte;
            hdr_cnt_q[ch] = CNT_W'(1);
            remaining_q[ch] = '0;
            phase_q[ch] = PHASE_IN_MSG;
        end else if (hdr_cnt_q[ch] < HEADER_BYTES) begin
            // Length arrives least significant byte first.
            remaining_q[ch] = remaining_q[ch]
                | (LEN_W'(req.data_byte) << (8 * (int'(hdr_cnt_q[ch]) - 1)));
            hdr_cnt_q[ch] = hdr_cnt_q[ch] + CNT_W'(1);
            if (hdr_cnt_q[ch] == HEADER_BYTES
                    && (remaining_q[ch] == '0 || remaining_q[ch] > max_payload_q)) begin
                phase_q[ch] = PHASE_WAIT_TYPE;
                produced = 1'b1;
                res.message_type = msg_type_q[ch];
                res.last = 1'b1;
                res.length_error = (remaining_q[ch] != '0);
            end
        end else begin
            remaining_q[ch] = remaining_q[ch] - LEN_W'(1);
            produced = 1'b1;
            res.message_type = msg_type_q[ch];
            res.payload_byte = req.data_byte;
            res.has_byte = 1'b1;
            res.last = (remaining_q[ch] == '0);
            if (res.last) begin
                phase_q[ch] = PHASE_WAIT_TYPE;
            end
        end
    endtask

    function automatic int field_diff(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
        if (want === got) begin
            return 0;
        end
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_in_item  req;
        t_out_item want;
        t_out_item got;
        bit        produced;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                phase_q[c] = PHASE_WAIT_TYPE;
                hdr_cnt_q[c] = '0;
                remaining_q[c] = '0;
                msg_type_q[c] = '0;
            end
            max_payload_q = MAX_PAYLOAD_RESET;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.out_channel = i_res.out_channel;
                got.message_type = i_res.message_type;
                got.payload_byte = i_res.payload_byte;
                got.has_byte = i_res.has_byte;
                got.last = i_res.last;
                got.length_error = i_res.length_error;
                if (expected_results.size() == 0) begin
                    $error("result on channel %0d arrived with none expected",
                           got.out_channel);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    mismatches += field_diff("out_channel", 8'(want.out_channel),
                                             8'(got.out_channel));
                    mismatches += field_diff("message_type", want.message_type,
                                             got.message_type);
                    mismatches += field_diff("payload_byte", want.payload_byte,
                                             got.payload_byte);
                    mismatches += field_diff("has_byte", 8'(want.has_byte),
                                             8'(got.has_byte));
                    mismatches += field_diff("last", 8'(want.last), 8'(got.last));
                    mismatches += field_diff("length_error", 8'(want.length_error),
                                             8'(got.length_error));
                end
            end
            if (i_req.valid && i_req.ready) begin
                req.kind = i_req.kind;
                req.channel = i_req.channel;
                req.data_byte = i_req.data_byte;
                deframe_step(req, produced, want);
                if (produced) begin
                    expected_results.push_back(want);
                end
            end
            if (i_cfg_we) begin
                max_payload_q = i_cfg_data;
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvd_pkg::*;

    localparam int NUM_CH = 1 << CH_W;
    localparam int HDR = int'(HEADER_BYTES);
    localparam int PHASES = 5;
    localparam int REQS_PER_PHASE = 340;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit quiet = 1'b0;

    // The length limit the block holds at present, as far as the stimulus knows.
    logic [LEN_W-1:0] cur_max = MAX_PAYLOAD_RESET;

    // Stimulus view of each channel: the message being sent, how far it has got,
    // and where it stops. A message may stop short of its full length, in which
    // case the channel is left dirty and the next thing sent on it is an open event.
    logic [BYTE_W-1:0] msg_type  [NUM_CH];
    logic [LEN_W-1:0]  msg_len   [NUM_CH];
    int                msg_pos   [NUM_CH];
    int                msg_end   [NUM_CH];
    bit                need_open [NUM_CH];

    tlvd_in_if  in_if ();
    tlvd_out_if out_if ();

    multichannel_type_length_deframer_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    tlvd_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (in_if),
        .i_res        (out_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Absolute bound on the run. It is far beyond what a correct run with the
    // worst idling on both sides could need, so reaching it means a hang.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver drops ready at random, except during the quiet stretch.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= quiet || ($urandom_range(99) >= 18);
        end
    end

    // Presents one request and returns at the edge at which it is taken. Random
    // idle cycles go in front of it; valid is only ever assigned once per edge,
    // so back-to-back requests keep valid high without a glitch.
    task automatic push_request(input logic kind, input logic [CH_W-1:0] ch,
                                input logic [BYTE_W-1:0] data);
        while (!quiet && $urandom_range(99) < 18) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.channel <= ch;
        in_if.data_byte <= data;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // How many requests a complete message occupies under the present limit:
    // an empty message and an over-long one both end with the header.
    function automatic int message_span(input logic [LEN_W-1:0] len);
        if (len == '0 || len > cur_max) begin
            return HDR;
        end
        return HDR + int'(len);
    endfunction

    // Writes a new length limit once the block has gone quiet. Every expected
    // result must have come back, and a few more cycles are allowed for a
    // header byte still in flight that gives no result but is checked against
    // the limit. Channels stay mid-message across the write on purpose.
    task automatic write_max(input logic [LEN_W-1:0] value);
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_max = value;
        // A channel still inside its header will be checked against the new
        // limit, so its planned end is worked out again. A message that would
        // now turn into a long payload is abandoned instead.
        for (int c = 0; c < NUM_CH; c++) begin
            if (msg_pos[c] < HDR && msg_pos[c] < msg_end[c] && !need_open[c]) begin
                if (message_span(msg_len[c]) > HDR + 64) begin
                    msg_end[c] = msg_pos[c];
                    need_open[c] = 1'b1;
                end else begin
                    msg_end[c] = message_span(msg_len[c]);
                end
            end
        end
    endtask

    // One random request. Most of them carry well-formed messages on random
    // channels, so several messages are interleaved at any time; a few are
    // stray bytes or open events that break into whatever is under way.
    task automatic random_step();
        int               c;
        int               r;
        int               cap;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        c = $urandom_range(NUM_CH - 1);
        if ($urandom_range(99) < 4) begin
            if ($urandom_range(1) == 1) begin
                push_request(KIND_OPEN, CH_W'(c), 8'($urandom()));
                need_open[c] = 1'b0;
            end else begin
                push_request(KIND_DATA, CH_W'(c), 8'($urandom()));
                need_open[c] = 1'b1;
            end
            msg_end[c] = msg_pos[c];
        end else if (msg_pos[c] == msg_end[c] && need_open[c]) begin
            push_request(KIND_OPEN, CH_W'(c), 8'($urandom()));
            need_open[c] = 1'b0;
        end else begin
            if (msg_pos[c] == msg_end[c]) begin
                // Start a new message. The length mix covers empty messages,
                // lengths just over and far over the limit, and lengths up to the limit or 20, whichever is smaller.
                r = $urandom_range(99);
                if (r < 12) begin
                    len = '0;
                end else if (r < 24 && cur_max != '1) begin
                    len = cur_max + LEN_W'(1);
                end else if (r < 32 && !cur_max[LEN_W-1]) begin
                    len = {1'b1, 31'($urandom())};
                end else if (cur_max == '0) begin
                    len = LEN_W'($urandom_range(4, 1));
                end else begin
                    cap = (cur_max < 20) ? int'(cur_max) : 20;
                    len = (r < 40) ? LEN_W'(cap) : LEN_W'($urandom_range(cap, 1));
                end
                msg_type[c] = 8'($urandom());
                msg_len[c] = len;
                msg_pos[c] = 0;
                msg_end[c] = message_span(len);
                if ($urandom_range(99) < 5) begin
                    msg_end[c] = int'($urandom_range(msg_end[c] - 1, 1));
                    need_open[c] = 1'b1;
                end
            end
            if (msg_pos[c] == 0) begin
                data = msg_type[c];
            end else if (msg_pos[c] < HDR) begin
                data = 8'(msg_len[c] >> (8 * (msg_pos[c] - 1)));
            end else begin
                data = 8'($urandom());
            end
            push_request(KIND_DATA, CH_W'(c), data);
            msg_pos[c]++;
        end
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] limits [PHASES];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.kind <= KIND_DATA;
        in_if.channel <= '0;
        in_if.data_byte <= '0;
        for (int c = 0; c < NUM_CH; c++) begin
            msg_type[c] = '0;
            msg_len[c] = '0;
            msg_pos[c] = 0;
            msg_end[c] = 0;
            need_open[c] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the limit loaded by reset.
        // An empty message on the lowest channel with an all-ones type.
        push_request(KIND_DATA, 4'd0, 8'hFF);
        repeat (4) push_request(KIND_DATA, 4'd0, 8'h00);
        // The largest possible length on the highest channel: flagged as an
        // error at the end of the header, with nothing following it.
        push_request(KIND_DATA, 4'd15, 8'h00);
        repeat (4) push_request(KIND_DATA, 4'd15, 8'hFF);
        // A two-byte message on the same channel, interleaved with a header
        // on channel 5 that an open event then cuts short.
        push_request(KIND_DATA, 4'd15, 8'hA5);
        push_request(KIND_DATA, 4'd15, 8'h02);
        repeat (3) push_request(KIND_DATA, 4'd15, 8'h00);
        push_request(KIND_DATA, 4'd5, 8'h3C);
        push_request(KIND_DATA, 4'd15, 8'h00);
        push_request(KIND_DATA, 4'd5, 8'h01);
        push_request(KIND_DATA, 4'd15, 8'hFF);
        push_request(KIND_OPEN, 4'd5, 8'hFF);
        // Channel 5 starts again from its type byte with a one-byte message.
        push_request(KIND_DATA, 4'd5, 8'h81);
        push_request(KIND_DATA, 4'd5, 8'h01);
        repeat (3) push_request(KIND_DATA, 4'd5, 8'h00);
        push_request(KIND_DATA, 4'd5, 8'h7E);

        // Random part in several phases, each under its own length limit. The
        // extremes are among them; the phase with the unbounded limit runs
        // without any idling on either side.
        limits[0] = LEN_W'(3);
        limits[1] = '0;
        limits[2] = '1;
        limits[3] = LEN_W'(16);
        limits[4] = LEN_W'($urandom());
        for (int p = 0; p < PHASES; p++) begin
            write_max(limits[p]);
            quiet = (p == 2);
            repeat (REQS_PER_PHASE) random_step();
        end
        quiet = 1'b0;

        // Let every expected result come back, then give the block a few more
        // cycles in which a stray result would still be caught.
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tlvd_pkg.sv
hdl/tlvd_if.sv
hdl/tlvd_ctx_store.sv
hdl/multichannel_type_length_deframer_top.sv
verif/tlvd_frame_checker.sv
verif/tb.sv
